@@ src/sine_cosine_polynomial_unit_top_macros.svh @@
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef SINE_COSINE_POLYNOMIAL_UNIT_TOP_MACROS_SVH
`define SINE_COSINE_POLYNOMIAL_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SCPU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SCPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCPU_ASSERT(label, prop, msg)
`define SCPU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ src/scpu_pkg.sv @@
package scpu_pkg;

	localparam int ANGLE_WIDTH  = 32;
	localparam int RESULT_WIDTH = 32;
	localparam int POLY_FRAC    = 30;
	localparam int TAN_FRAC     = RESULT_WIDTH / 2;

	// reduction format: 56 fraction bits, angle magnitude shifted left by 32
	localparam int RED_STEPS = 5;
	localparam int RED_W     = 60;
	localparam int FRONT_N   = RED_STEPS + 4;

	localparam logic [63:0] TWO_PI_Q61  = 64'hC90FDAA22168C235;
	localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
	localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
	localparam logic [63:0] TWO_PI_R  = (TWO_PI_Q61 >> 5) + ((TWO_PI_Q61 >> 4) & 64'd1);
	localparam logic [63:0] PI_R      = (PI_Q61 >> 5) + ((PI_Q61 >> 4) & 64'd1);
	localparam logic [63:0] HALF_PI_R = (HALF_PI_Q61 >> 5) + ((HALF_PI_Q61 >> 4) & 64'd1);

	localparam int XR_W = 31;
	localparam int PW   = 34;

	localparam logic signed [PW-1:0] S1 = 34'sd1073741824;
	localparam logic signed [PW-1:0] S3 = -34'sd178956971;
	localparam logic signed [PW-1:0] S5 = 34'sd8947849;
	localparam logic signed [PW-1:0] S7 = -34'sd213044;
	localparam logic signed [PW-1:0] C0 = 34'sd1073741824;
	localparam logic signed [PW-1:0] C2 = -34'sd536870912;
	localparam logic signed [PW-1:0] C4 = 34'sd44739243;
	localparam logic signed [PW-1:0] C6 = -34'sd1491308;
	localparam logic signed [PW-1:0] C8 = 34'sd26631;

	localparam int REM_W     = PW + TAN_FRAC + 1;
	localparam int CMP_W     = PW + RESULT_WIDTH;
	localparam int DIV_STEPS = RESULT_WIDTH;
	localparam int DV_LAST   = DIV_STEPS + 1;

	localparam logic [RESULT_WIDTH-1:0] RES_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
	localparam logic [RESULT_WIDTH-1:0] RES_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [1:0] {
		OP_SIN = 2'd0,
		OP_COS = 2'd1,
		OP_TAN = 2'd2
	} scpu_op_t;

	typedef struct packed {
		scpu_op_t         op;
		logic             xneg;
		logic             cneg;
		logic [XR_W-1:0]  xr;
	} scpu_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} scpu_qstat_t;

	// Q.30 product, rounded half away from zero
	function automatic logic signed [PW-1:0] qmul(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b);
		logic [PW-1:0]   ma;
		logic [PW-1:0]   mb;
		logic [2*PW-1:0] p;
		logic [PW-1:0]   m;
		ma = a[PW-1] ? (PW'(0) - PW'(a)) : PW'(a);
		mb = b[PW-1] ? (PW'(0) - PW'(b)) : PW'(b);
		p  = ma * mb;
		p  = p + ((2*PW)'(1) << (POLY_FRAC - 1));
		m  = p[POLY_FRAC +: PW];
		return (a[PW-1] ^ b[PW-1]) ? (PW'(0) - m) : m;
	endfunction

endpackage

@@ src/sine_cosine_polynomial_unit_top.sv @@
// Throughput: one item per cycle while nothing stalls; the 32-stage tangent divider sets the back depth.
// Front: 9 stages of range reduction and folding, then a 4-entry queue.
// Back: 5 polynomial stages, operand setup, range check, 32 division stages,
// output register.
// Reset clears the valid bits, queue pointers and queue count only; no clearing pass.
`include "sine_cosine_polynomial_unit_top_macros.svh"

module sine_cosine_polynomial_unit_top import scpu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [1:0]              opcode,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [RESULT_WIDTH-1:0] value,
	output logic                    overflow
);

	scpu_qstat_t qstat;
	scpu_item_t  f_item;
	scpu_item_t  q_item;
	logic        push;
	logic        pop;
	logic [RESULT_WIDTH-1:0] value_raw;

	scpu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.angle      (angle),
		.qstat      (qstat),
		.push       (push),
		.item       (f_item)
	);

	scpu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (f_item),
		.pop     (pop),
		.rd_item (q_item),
		.qstat   (qstat)
	);

	scpu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_item),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value_raw),
		.overflow     (overflow)
	);

	assign value = $signed(value_raw);

	`SCPU_ASSERT(a_sat_bound, result_valid && overflow |-> (value_raw == RES_MAX || value_raw == RES_MIN), "overflow beat without saturated value")
	`SCPU_ASSERT_NEXT(a_queue_keeps, qstat.full && !pop, !qstat.empty, "queue lost entries while full")
	`SCPU_ASSERT(a_no_pop_empty, qstat.empty |-> !pop, "pop from empty queue")

endmodule

@@ src/scpu_front.sv @@
module scpu_front import scpu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [1:0]              opcode,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	input  scpu_qstat_t             qstat,
	output logic                    push,
	output scpu_item_t              item
);

	logic [FRONT_N-1:0]   vld_s;
	scpu_op_t             op_s   [0:FRONT_N-1];
	logic                 aneg_s [0:RED_STEPS];
	logic [63:0]          rem_s  [0:RED_STEPS];
	logic                 xneg_s6, xneg_s7, xneg_s8;
	logic [RED_W-1:0]     xabs_s6;
	logic                 cneg_s7, cneg_s8;
	logic [RED_W-1:0]     dabs_s7;
	logic [XR_W-1:0]      xr_s8;

	logic                 adv;
	logic [ANGLE_WIDTH-1:0] mag;
	logic [63:0]          rem_nxt [1:RED_STEPS];
	logic [63:0]          sub_sh  [1:RED_STEPS];
	logic signed [63:0]   r;
	logic signed [RED_W:0] d;
	logic [RED_W-1:0]     red;

	assign adv        = !(vld_s[FRONT_N-1] && qstat.full);
	assign item_stall = !adv;
	assign push       = vld_s[FRONT_N-1] && !qstat.full;

	always_comb begin
		mag = angle[ANGLE_WIDTH-1] ? (ANGLE_WIDTH'(0) - ANGLE_WIDTH'(angle))
			: ANGLE_WIDTH'(angle);
		// restoring reduction, each stage subtracting 16, 8, 4, 2 or 1 times 2pi when it fits
		for (int k = 1; k <= RED_STEPS; k++) begin
			sub_sh[k]  = TWO_PI_R << (RED_STEPS - k);
			rem_nxt[k] = (rem_s[k-1] >= sub_sh[k]) ? (rem_s[k-1] - sub_sh[k]) : rem_s[k-1];
		end
		r   = $signed(rem_s[RED_STEPS]) - $signed(PI_R);
		d   = $signed({1'b0, xabs_s6}) - $signed({1'b0, HALF_PI_R[RED_W-1:0]});
		red = HALF_PI_R[RED_W-1:0] - dabs_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[FRONT_N-2:0], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[0]   <= scpu_op_t'(opcode);
			aneg_s[0] <= angle[ANGLE_WIDTH-1];
			rem_s[0]  <= {mag, 32'd0} + PI_R;
			for (int k = 1; k < FRONT_N; k++) begin
				op_s[k] <= op_s[k-1];
			end
			for (int k = 1; k <= RED_STEPS; k++) begin
				aneg_s[k] <= aneg_s[k-1];
				rem_s[k]  <= rem_nxt[k];
			end
			xneg_s6 <= aneg_s[RED_STEPS] ? (r > 0) : (r < 0);
			xabs_s6 <= r[63] ? RED_W'(64'd0 - r) : r[RED_W-1:0];
			xneg_s7 <= xneg_s6;
			cneg_s7 <= xabs_s6 >= HALF_PI_R[RED_W-1:0];
			dabs_s7 <= d[RED_W] ? RED_W'((RED_W+1)'(0) - d) : d[RED_W-1:0];
			xneg_s8 <= xneg_s7;
			cneg_s8 <= cneg_s7;
			xr_s8   <= red[26 +: XR_W] + XR_W'(red[25]);
		end
	end

	assign item.op   = op_s[FRONT_N-1];
	assign item.xneg = xneg_s8;
	assign item.cneg = cneg_s8;
	assign item.xr   = xr_s8;

endmodule

@@ src/scpu_queue.sv @@
module scpu_queue import scpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  scpu_item_t  wr_item,
	input  logic        pop,
	output scpu_item_t  rd_item,
	output scpu_qstat_t qstat
);

	scpu_item_t        mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign qstat.full  = count_q == QCNT_W'(QDEPTH);
	assign qstat.empty = count_q == '0;
	assign rd_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

@@ src/scpu_back.sv @@
module scpu_back import scpu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  scpu_item_t              head,
	input  scpu_qstat_t             qstat,
	output logic                    pop,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [RESULT_WIDTH-1:0] value,
	output logic                    overflow
);

	typedef struct packed {
		scpu_op_t                op;
		logic [RESULT_WIDTH-1:0] scv;
		logic                    sneg;
		logic                    qneg;
		logic                    czero;
		logic                    hi;
		logic [PW-1:0]           mc;
		logic [REM_W-1:0]        rem;
		logic [RESULT_WIDTH-1:0] quo;
	} dv_t;

	logic                   adv;
	logic [4:0]             pvld_s;
	scpu_op_t               op_s   [0:4];
	logic                   xneg_s [0:4];
	logic                   cneg_s [0:4];
	logic signed [PW-1:0]   xr_s   [0:4];
	logic signed [PW-1:0]   x2_s   [0:4];
	logic signed [PW-1:0]   sp_s   [1:4];
	logic signed [PW-1:0]   cp_s   [1:4];
	logic [DV_LAST:0]       dvld_s;
	dv_t                    dv_s   [0:DV_LAST];
	dv_t                    dv_nxt [1:DV_LAST];
	logic                   rvld_q;
	logic [RESULT_WIDTH-1:0] value_q;
	logic                   ovf_q;

	logic signed [PW-1:0]   xr_in;
	logic signed [PW-1:0]   s_full;
	logic signed [PW-1:0]   c_full;
	logic [PW-1:0]          ms;
	logic [PW-1:0]          mc;
	logic [CMP_W-1:0]       trial [1:DV_LAST];
	logic [RESULT_WIDTH-1:0] out_val;
	logic                   out_ovf;
	dv_t                    fin;

	assign adv          = !(rvld_q && result_stall);
	assign pop          = adv && !qstat.empty;
	assign result_valid = rvld_q;
	assign value        = value_q;
	assign overflow     = ovf_q;
	assign xr_in        = $signed(PW'(head.xr));
	assign fin          = dv_s[DV_LAST];

	always_comb begin
		s_full = xneg_s[4] ? (PW'(0) - sp_s[4]) : sp_s[4];
		c_full = cneg_s[4] ? (PW'(0) - cp_s[4]) : cp_s[4];
		ms     = sp_s[4][PW-1] ? (PW'(0) - PW'(sp_s[4])) : PW'(sp_s[4]);
		mc     = cp_s[4][PW-1] ? (PW'(0) - PW'(cp_s[4])) : PW'(cp_s[4]);
		// long division, one quotient bit per stage after the range check
		for (int k = 1; k <= DV_LAST; k++) begin
			dv_nxt[k] = dv_s[k-1];
			trial[k]  = '0;
			if (k == 1) begin
				dv_nxt[k].hi = CMP_W'(dv_s[k-1].rem) >= (CMP_W'(dv_s[k-1].mc) << RESULT_WIDTH);
			end else begin
				trial[k] = CMP_W'(dv_s[k-1].mc) << (DV_LAST - k);
				if (CMP_W'(dv_s[k-1].rem) >= trial[k]) begin
					dv_nxt[k].rem = dv_s[k-1].rem - trial[k][REM_W-1:0];
					dv_nxt[k].quo[DV_LAST - k] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		out_val = '0;
		out_ovf = 1'b0;
		unique case (fin.op)
			OP_SIN, OP_COS: begin
				out_val = fin.scv;
			end
			OP_TAN: begin
				if (fin.czero) begin
					out_ovf = 1'b1;
					out_val = fin.sneg ? RES_MIN : RES_MAX;
				end else if (fin.hi) begin
					out_ovf = 1'b1;
					out_val = fin.qneg ? RES_MIN : RES_MAX;
				end else if (fin.qneg && fin.quo > RES_MIN) begin
					out_ovf = 1'b1;
					out_val = RES_MIN;
				end else if (!fin.qneg && fin.quo[RESULT_WIDTH-1]) begin
					out_ovf = 1'b1;
					out_val = RES_MAX;
				end else begin
					out_val = fin.qneg ? (RESULT_WIDTH'(0) - fin.quo) : fin.quo;
				end
			end
			default: begin
				out_val = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_s <= '0;
			dvld_s <= '0;
			rvld_q <= 1'b0;
		end else if (adv) begin
			pvld_s <= {pvld_s[3:0], pop};
			dvld_s <= {dvld_s[DV_LAST-1:0], pvld_s[4]};
			rvld_q <= dvld_s[DV_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[0]   <= head.op;
			xneg_s[0] <= head.xneg;
			cneg_s[0] <= head.cneg;
			xr_s[0]   <= xr_in;
			x2_s[0]   <= qmul(xr_in, xr_in);
			for (int k = 1; k <= 4; k++) begin
				op_s[k]   <= op_s[k-1];
				xneg_s[k] <= xneg_s[k-1];
				cneg_s[k] <= cneg_s[k-1];
				xr_s[k]   <= xr_s[k-1];
				x2_s[k]   <= x2_s[k-1];
			end
			// Horner steps, sine and cosine side by side
			sp_s[1] <= S5 + qmul(x2_s[0], S7);
			cp_s[1] <= C6 + qmul(x2_s[0], C8);
			sp_s[2] <= S3 + qmul(x2_s[1], sp_s[1]);
			cp_s[2] <= C4 + qmul(x2_s[1], cp_s[1]);
			sp_s[3] <= S1 + qmul(x2_s[2], sp_s[2]);
			cp_s[3] <= C2 + qmul(x2_s[2], cp_s[2]);
			sp_s[4] <= qmul(xr_s[3], sp_s[3]);
			cp_s[4] <= C0 + qmul(x2_s[3], cp_s[3]);

			dv_s[0].op    <= op_s[4];
			dv_s[0].scv   <= (op_s[4] == OP_SIN) ? s_full[RESULT_WIDTH-1:0]
				: c_full[RESULT_WIDTH-1:0];
			dv_s[0].sneg  <= s_full[PW-1];
			dv_s[0].qneg  <= s_full[PW-1] ^ c_full[PW-1];
			dv_s[0].czero <= cp_s[4] == '0;
			dv_s[0].hi    <= 1'b0;
			dv_s[0].mc    <= mc;
			dv_s[0].rem   <= REM_W'({ms, {TAN_FRAC{1'b0}}}) + REM_W'(mc >> 1);
			dv_s[0].quo   <= '0;
			for (int k = 1; k <= DV_LAST; k++) begin
				dv_s[k] <= dv_nxt[k];
			end
			value_q <= out_val;
			ovf_q   <= out_ovf;
		end
	end

endmodule
